// File: hw/rtl/mde_pkg.sv
// types and constants shared by the decode/execute unit
`timescale 1ns / 1ps
package mde_pkg;

   localparam int ReqWidth = 136;
   localparam int RspWidth = 144;
   localparam int CntWidth = 6;

   localparam logic [5:0] OPC_SPECIAL = 6'h00;
   localparam logic [5:0] OPC_REGIMM  = 6'h01;
   localparam logic [5:0] OPC_J       = 6'h02;
   localparam logic [5:0] OPC_JAL     = 6'h03;
   localparam logic [5:0] OPC_BEQ     = 6'h04;
   localparam logic [5:0] OPC_BNE     = 6'h05;
   localparam logic [5:0] OPC_BLEZ    = 6'h06;
   localparam logic [5:0] OPC_BGTZ    = 6'h07;
   localparam logic [5:0] OPC_ADDI    = 6'h08;
   localparam logic [5:0] OPC_ADDIU   = 6'h09;
   localparam logic [5:0] OPC_SLTI    = 6'h0A;
   localparam logic [5:0] OPC_SLTIU   = 6'h0B;
   localparam logic [5:0] OPC_ANDI    = 6'h0C;
   localparam logic [5:0] OPC_ORI     = 6'h0D;
   localparam logic [5:0] OPC_XORI    = 6'h0E;
   localparam logic [5:0] OPC_LUI     = 6'h0F;
   localparam logic [5:0] OPC_LB      = 6'h20;
   localparam logic [5:0] OPC_LH      = 6'h21;
   localparam logic [5:0] OPC_LW      = 6'h23;
   localparam logic [5:0] OPC_LBU     = 6'h24;
   localparam logic [5:0] OPC_LHU     = 6'h25;
   localparam logic [5:0] OPC_SB      = 6'h28;
   localparam logic [5:0] OPC_SH      = 6'h29;
   localparam logic [5:0] OPC_SW      = 6'h2B;

   localparam logic [5:0] FN_SLL     = 6'h00;
   localparam logic [5:0] FN_SRL     = 6'h02;
   localparam logic [5:0] FN_SRA     = 6'h03;
   localparam logic [5:0] FN_SLLV    = 6'h04;
   localparam logic [5:0] FN_SRLV    = 6'h06;
   localparam logic [5:0] FN_SRAV    = 6'h07;
   localparam logic [5:0] FN_JR      = 6'h08;
   localparam logic [5:0] FN_JALR    = 6'h09;
   localparam logic [5:0] FN_SYSCALL = 6'h0C;
   localparam logic [5:0] FN_MFHI    = 6'h10;
   localparam logic [5:0] FN_MTHI    = 6'h11;
   localparam logic [5:0] FN_MFLO    = 6'h12;
   localparam logic [5:0] FN_MTLO    = 6'h13;
   localparam logic [5:0] FN_MULT    = 6'h18;
   localparam logic [5:0] FN_MULTU   = 6'h19;
   localparam logic [5:0] FN_DIV     = 6'h1A;
   localparam logic [5:0] FN_DIVU    = 6'h1B;
   localparam logic [5:0] FN_ADD     = 6'h20;
   localparam logic [5:0] FN_ADDU    = 6'h21;
   localparam logic [5:0] FN_SUB     = 6'h22;
   localparam logic [5:0] FN_SUBU    = 6'h23;
   localparam logic [5:0] FN_AND     = 6'h24;
   localparam logic [5:0] FN_OR      = 6'h25;
   localparam logic [5:0] FN_XOR     = 6'h26;
   localparam logic [5:0] FN_NOR     = 6'h27;
   localparam logic [5:0] FN_SLT     = 6'h2A;
   localparam logic [5:0] FN_SLTU    = 6'h2B;

   localparam logic [4:0] RI_BLTZ   = 5'h00;
   localparam logic [4:0] RI_BGEZ   = 5'h01;
   localparam logic [4:0] RI_BLTZAL = 5'h10;
   localparam logic [4:0] RI_BGEZAL = 5'h11;

   localparam logic [4:0] REG_RA = 5'd31;
   localparam logic [31:0] SYS_EXIT = 32'hA;

   localparam logic [3:0] MK_NONE = 4'd0;
   localparam logic [3:0] MK_LW   = 4'd1;
   localparam logic [3:0] MK_LH   = 4'd2;
   localparam logic [3:0] MK_LHU  = 4'd3;
   localparam logic [3:0] MK_LB   = 4'd4;
   localparam logic [3:0] MK_LBU  = 4'd5;
   localparam logic [3:0] MK_SW   = 4'd6;
   localparam logic [3:0] MK_SH   = 4'd7;
   localparam logic [3:0] MK_SB   = 4'd8;

   typedef struct packed {
      logic        is_instr;
      logic [31:0] pc;
      logic [31:0] iw;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] pc4;
      logic [31:0] simm;
      logic [31:0] btarg;
      logic [31:0] jtarg;
      logic [3:0]  kind;
   } dec_type;

   typedef struct packed {
      logic        halt;
      logic        retry;
      logic [3:0]  kind;
      logic [31:0] sdata;
      logic [31:0] addr;
      logic [31:0] target;
      logic        taken;
      logic        wr;
      logic [4:0]  dst;
      logic [31:0] res;
   } rsp_type;

endpackage

// File: hw/rtl/mips_decode_execute_unit_top.sv
// top level of the mips32 decode/execute unit
//
// req channel carries one item per transfer: a bubble (op = 0) or an
// instruction with pc and the two source register values. each
// instruction gives exactly one rsp transfer; a bubble gives none but
// still ticks the hi/lo busy counter.
// rsp_tvalid rises once the req item has passed the queue entry and then
// the back-end output register.
// throughput: one item per cycle for plain instructions while rsp is not
// stalled; mult/multu hold the back end for the registered product, and
// div/divu hold it for the one-bit-per-cycle divider.
// a two-entry queue lets req keep flowing while the back end is busy;
// when rsp is stalled the output register holds and the queue fills,
// then req_tready drops.
// reset clears hi, lo, the busy counter, the queue and rsp_tvalid.
`timescale 1ns / 1ps
module mips_decode_execute_unit_top #(
   parameter int MUL_LATENCY = 4,
   parameter int DIV_LATENCY = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // op, pc, instr_word, src1_value, src2_value
   input  logic [mde_pkg::ReqWidth-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // result_value, write_reg, write_enable, jump_taken, branch_target,
   // mem_address, store_data, mem_kind, retry, halt
   output logic [mde_pkg::RspWidth-1:0] rsp_tdata
);
   import mde_pkg::*;

   logic    push, q_full, q_not_empty, pop;
   dec_type push_item, head;

   mde_front u_front (
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .push(push), .push_item(push_item), .q_full(q_full)
   );

   mde_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .full(q_full), .pop(pop), .not_empty(q_not_empty), .head(head)
   );

   mde_exec #(.MUL_LATENCY(MUL_LATENCY), .DIV_LATENCY(DIV_LATENCY)) u_exec (
      .clock(clock), .reset(reset), .q_not_empty(q_not_empty), .head(head),
      .pop(pop), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );
endmodule

// File: hw/rtl/mde_front.sv
// front end: accepts items and precomputes decode fields
`timescale 1ns / 1ps
module mde_front (
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mde_pkg::ReqWidth-1:0]   req_tdata,
   output logic                           push,
   output mde_pkg::dec_type               push_item,
   input  logic                           q_full
);
   import mde_pkg::*;

   logic [31:0] iw;
   logic [15:0] imm;

   assign iw  = req_tdata[64:33];
   assign imm = iw[15:0];
   assign req_tready = !q_full;
   assign push = req_tvalid && !q_full;

   always_comb begin
      push_item.is_instr = req_tdata[0];
      push_item.pc       = req_tdata[32:1];
      push_item.iw       = iw;
      push_item.a        = req_tdata[96:65];
      push_item.b        = req_tdata[128:97];
      push_item.pc4      = req_tdata[32:1] + 32'd4;
      push_item.simm     = {{16{imm[15]}}, imm};
      push_item.btarg    = req_tdata[32:1] + 32'd4 + {{14{imm[15]}}, imm, 2'b00};
      push_item.jtarg    = {req_tdata[32:29], iw[25:0], 2'b00};
      case (iw[31:26])
         OPC_LW:  push_item.kind = MK_LW;
         OPC_LH:  push_item.kind = MK_LH;
         OPC_LHU: push_item.kind = MK_LHU;
         OPC_LB:  push_item.kind = MK_LB;
         OPC_LBU: push_item.kind = MK_LBU;
         OPC_SW:  push_item.kind = MK_SW;
         OPC_SH:  push_item.kind = MK_SH;
         OPC_SB:  push_item.kind = MK_SB;
         default: push_item.kind = MK_NONE;
      endcase
   end
endmodule

// File: hw/rtl/mde_queue.sv
// two-entry queue between front and back end
`timescale 1ns / 1ps
module mde_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mde_pkg::dec_type push_item,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output mde_pkg::dec_type head
);
   import mde_pkg::*;

   dec_type     mem_ff [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? !wp_ff : wp_ff;
      rp_in  = pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= push_item;
   end
endmodule

// File: hw/rtl/mde_exec.sv
// back end: executes items, holds hi/lo, busy counter, multiplier and divider
`timescale 1ns / 1ps
module mde_exec #(
   parameter int MUL_LATENCY = 4,
   parameter int DIV_LATENCY = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_not_empty,
   input  mde_pkg::dec_type             head,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [mde_pkg::RspWidth-1:0] rsp_tdata
);
   import mde_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DFIN = 2'd3;

   logic [1:0]          st_ff, st_in;
   logic [31:0]         hi_ff, hi_in, lo_ff, lo_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in, cnt_dec;
   logic [63:0]         prod_ff, prod_in;
   logic [31:0]         rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [4:0]          step_ff, step_in;
   logic                negq_ff, negq_in, negr_ff, negr_in, dz_ff, dz_in;
   logic                vld_ff, vld_in;
   rsp_type             out_ff, out_in, r;
   logic                slot_free, busy, sgn;
   logic [5:0]          opc, fn;
   logic [4:0]          rt, rd, sh;
   logic [31:0]         a, b, amag, bmag;
   logic [65:0]         prod_full;
   logic [32:0]         sh_rem, diff;

   assign opc = head.iw[31:26];
   assign fn  = head.iw[5:0];
   assign rt  = head.iw[20:16];
   assign rd  = head.iw[15:11];
   assign sh  = head.iw[10:6];
   assign a   = head.a;
   assign b   = head.b;
   assign slot_free = !vld_ff || rsp_tready;
   assign pop = (st_ff == S_IDLE) && q_not_empty && (!head.is_instr || slot_free);
   assign cnt_dec = (cnt_ff != '0) ? cnt_ff - 1'b1 : cnt_ff;
   assign busy = cnt_dec != '0;
   assign sgn = fn == FN_MULT || fn == FN_DIV;
   assign amag = (sgn && a[31]) ? 32'd0 - a : a;
   assign bmag = (sgn && b[31]) ? 32'd0 - b : b;
   assign prod_full = $signed({sgn & a[31], a}) * $signed({sgn & b[31], b});
   assign sh_rem = {rem_ff, quo_ff[31]};
   assign diff = sh_rem - {1'b0, dvs_ff};

   always_comb begin
      r = '0;
      hi_in = hi_ff;
      lo_in = lo_ff;
      cnt_in = cnt_ff;
      st_in = st_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      step_in = step_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      dz_in = dz_ff;
      case (st_ff)
         S_MUL: begin
            hi_in = prod_ff[63:32];
            lo_in = prod_ff[31:0];
            st_in = S_IDLE;
         end
         S_DIV: begin
            if (!diff[32]) begin
               rem_in = diff[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = sh_rem[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd31) st_in = S_DFIN;
         end
         S_DFIN: begin
            lo_in = dz_ff ? 32'd0 : (negq_ff ? 32'd0 - quo_ff : quo_ff);
            hi_in = dz_ff ? 32'd0 : (negr_ff ? 32'd0 - rem_ff : rem_ff);
            st_in = S_IDLE;
         end
         default: begin
            if (pop) begin
               cnt_in = cnt_dec;
               if (head.is_instr) begin
                  case (opc)
                     OPC_SPECIAL: begin
                        case (fn)
                           FN_SLL: begin r.res = b << sh; r.dst = rd; r.wr = 1'b1; end
                           FN_SRL: begin r.res = b >> sh; r.dst = rd; r.wr = 1'b1; end
                           FN_SRA: begin
                              r.res = $unsigned($signed(b) >>> sh); r.dst = rd; r.wr = 1'b1;
                           end
                           FN_SLLV: begin r.res = b << a[4:0]; r.dst = rd; r.wr = 1'b1; end
                           FN_SRLV: begin r.res = b >> a[4:0]; r.dst = rd; r.wr = 1'b1; end
                           FN_SRAV: begin
                              r.res = $unsigned($signed(b) >>> a[4:0]); r.dst = rd;
                              r.wr = 1'b1;
                           end
                           FN_JR: begin r.taken = 1'b1; r.target = a; end
                           FN_JALR: begin
                              r.taken = 1'b1; r.target = a; r.res = head.pc4; r.dst = rd;
                              r.wr = 1'b1;
                           end
                           FN_SYSCALL: r.halt = a == SYS_EXIT;
                           FN_MFHI: begin
                              if (busy) r.retry = 1'b1;
                              else begin r.res = hi_ff; r.dst = rd; r.wr = 1'b1; end
                           end
                           FN_MFLO: begin
                              if (busy) r.retry = 1'b1;
                              else begin r.res = lo_ff; r.dst = rd; r.wr = 1'b1; end
                           end
                           FN_MTHI: begin
                              if (busy) r.retry = 1'b1;
                              else hi_in = a;
                           end
                           FN_MTLO: begin
                              if (busy) r.retry = 1'b1;
                              else lo_in = a;
                           end
                           FN_MULT, FN_MULTU: begin
                              prod_in = prod_full[63:0];
                              cnt_in = CntWidth'(MUL_LATENCY);
                              st_in = S_MUL;
                           end
                           FN_DIV, FN_DIVU: begin
                              rem_in = '0;
                              quo_in = amag;
                              dvs_in = bmag;
                              step_in = '0;
                              negq_in = sgn && (a[31] ^ b[31]);
                              negr_in = sgn && a[31];
                              dz_in = b == 32'd0;
                              cnt_in = CntWidth'(DIV_LATENCY);
                              st_in = S_DIV;
                           end
                           FN_ADD, FN_ADDU: begin r.res = a + b; r.dst = rd; r.wr = 1'b1; end
                           FN_SUB, FN_SUBU: begin r.res = a - b; r.dst = rd; r.wr = 1'b1; end
                           FN_AND: begin r.res = a & b; r.dst = rd; r.wr = 1'b1; end
                           FN_OR:  begin r.res = a | b; r.dst = rd; r.wr = 1'b1; end
                           FN_XOR: begin r.res = a ^ b; r.dst = rd; r.wr = 1'b1; end
                           FN_NOR: begin r.res = ~(a | b); r.dst = rd; r.wr = 1'b1; end
                           FN_SLT: begin
                              r.res = {31'd0, $signed(a) < $signed(b)}; r.dst = rd;
                              r.wr = 1'b1;
                           end
                           FN_SLTU: begin r.res = {31'd0, a < b}; r.dst = rd; r.wr = 1'b1; end
                           default: r = '0;
                        endcase
                     end
                     OPC_REGIMM: begin
                        if (rt == RI_BLTZ || rt == RI_BLTZAL) r.taken = a[31];
                        else if (rt == RI_BGEZ || rt == RI_BGEZAL) r.taken = !a[31];
                        if (rt == RI_BLTZAL || rt == RI_BGEZAL) begin
                           r.res = head.pc4; r.dst = REG_RA; r.wr = 1'b1;
                        end
                        r.target = head.btarg;
                     end
                     OPC_JAL: begin
                        r.res = head.pc4; r.dst = REG_RA; r.wr = 1'b1;
                        r.taken = 1'b1; r.target = head.jtarg;
                     end
                     OPC_J: begin r.taken = 1'b1; r.target = head.jtarg; end
                     OPC_BEQ: begin r.taken = a == b; r.target = head.btarg; end
                     OPC_BNE: begin r.taken = a != b; r.target = head.btarg; end
                     OPC_BLEZ: begin
                        r.taken = a[31] || a == 32'd0; r.target = head.btarg;
                     end
                     OPC_BGTZ: begin
                        r.taken = !a[31] && a != 32'd0; r.target = head.btarg;
                     end
                     OPC_ADDI, OPC_ADDIU: begin
                        r.res = a + head.simm; r.dst = rt; r.wr = 1'b1;
                     end
                     OPC_SLTI: begin
                        r.res = {31'd0, $signed(a) < $signed(head.simm)}; r.dst = rt;
                        r.wr = 1'b1;
                     end
                     OPC_SLTIU: begin
                        r.res = {31'd0, a < head.simm}; r.dst = rt; r.wr = 1'b1;
                     end
                     OPC_ANDI: begin r.res = a & {16'd0, head.iw[15:0]}; r.dst = rt; r.wr = 1'b1; end
                     OPC_ORI:  begin r.res = a | {16'd0, head.iw[15:0]}; r.dst = rt; r.wr = 1'b1; end
                     OPC_XORI: begin r.res = a ^ {16'd0, head.iw[15:0]}; r.dst = rt; r.wr = 1'b1; end
                     OPC_LUI:  begin r.res = {head.iw[15:0], 16'd0}; r.dst = rt; r.wr = 1'b1; end
                     default: r = '0;
                  endcase
                  if (head.kind != MK_NONE) begin
                     r.kind = head.kind;
                     r.addr = a + head.simm;
                     if (head.kind >= MK_SW) r.sdata = b;
                     else begin r.dst = rt; r.wr = 1'b1; r.res = '0; end
                  end
                  if (!r.wr || r.dst == 5'd0) begin
                     r.wr = 1'b0; r.dst = 5'd0; r.res = '0;
                  end
                  if (!r.taken) r.target = '0;
               end
            end
         end
      endcase
   end

   always_comb begin
      vld_in = (pop && head.is_instr) || (vld_ff && !rsp_tready);
      out_in = (pop && head.is_instr) ? r : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         cnt_ff <= '0;
         hi_ff  <= '0;
         lo_ff  <= '0;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         hi_ff  <= hi_in;
         lo_ff  <= lo_in;
         vld_ff <= vld_in;
      end
      out_ff  <= out_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      dz_ff   <= dz_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {3'd0, out_ff};
endmodule

// File: hw/rtl/mde_checker.sv
// port-level checks for the decode/execute unit
`timescale 1ns / 1ps
module mde_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [mde_pkg::RspWidth-1:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp dropped while stalled");
   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp data changed while stalled");
   a_retry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[139] |-> !rsp_tdata[37] && !rsp_tdata[38])
      else $error("retry with write or branch");
   a_wreg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37] |-> rsp_tdata[36:32] != 5'd0)
      else $error("write to register zero");
endmodule

bind mips_decode_execute_unit_top mde_checker u_mde_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
